// ===== hw/rtl/amdc_pkg.sv =====
// Shared types and constants for the audio mixer with low-pass and DC cut.
// Used by every module under hw/rtl; depends on nothing else.
package amdc_pkg;

  typedef struct packed {
    logic signed [15:0] channel_sample;
    logic [8:0]         channel_gain;
    logic               last_channel;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample_word;
    logic [7:0]         sample_byte;
  } out_beat_t;

  // mixed sum of one sample period, handed from the mixer to the filter
  typedef struct packed {
    logic               mute;
    logic signed [31:0] sum;
  } mix_beat_t;

  // filtered sample, handed from the filter to the DC cut
  typedef struct packed {
    logic               mute;
    logic signed [23:0] x;
  } lp_beat_t;

  localparam logic [0:0] CFG_ENABLE      = 1'd0;
  localparam logic [0:0] CFG_FILTER_MODE = 1'd1;

  localparam logic [1:0] FILT_NONE      = 2'd0;
  localparam logic [1:0] FILT_TWO_TAP   = 2'd1;
  localparam logic [1:0] FILT_THREE_TAP = 2'd2;

  localparam int MIX_SHIFT        = 8;
  localparam int PEAK_DECAY_SHIFT = 15;
  localparam int DC_LEAK_SHIFT    = 10;
  localparam int DC_SUM_SHIFT     = 11;

  localparam int WORD_MAX = 32767;
  localparam int WORD_MIN = -32768;

  localparam logic [7:0] BYTE_FLIP = 8'h80;

endpackage

// ===== hw/rtl/audio_mix_filter_dc_cut.sv =====
// Top level of the audio mixer: mix, low-pass, DC cut and saturate.
// Depends on amdc_pkg, amdc_mix, amdc_lowpass and amdc_dc_cut.
//
//   channel  | direction | handshake              | beat
//   in       | input     | in_valid / in_stall    | amdc_pkg::in_beat_t
//   out      | output    | out_valid / out_stall  | amdc_pkg::out_beat_t
//   cfg      | input     | cfg_write (no wait)    | cfg_index, cfg_data
//
// One channel beat is taken every cycle unless in_stall is high. The mixer
// holds an input and a sum register; filter and DC cut hold one register
// stage each and hand on one beat per cycle unless stalled.
// Reset is synchronous: accumulator, filter history and DC tracker clear,
// enable goes to 1 and filter mode to none.
// A stalled output holds its beat; stall reaches the input only when every
// stage in between is full.
module audio_mix_filter_dc_cut #(
  parameter int FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  amdc_pkg::in_beat_t  in_beat,
  output logic                in_stall,
  output logic                out_valid,
  output amdc_pkg::out_beat_t out_beat,
  input  logic                out_stall,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [1:0]          cfg_data
);

  logic                enable;
  logic [1:0]          filter_mode;
  logic                mix_valid;
  amdc_pkg::mix_beat_t mix_beat;
  logic                mix_take;
  logic                lp_valid;
  amdc_pkg::lp_beat_t  lp_beat;
  logic                lp_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b1;
      filter_mode <= amdc_pkg::FILT_NONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        amdc_pkg::CFG_ENABLE:      enable      <= cfg_data[0];
        amdc_pkg::CFG_FILTER_MODE: filter_mode <= cfg_data;
        default:                   ;
      endcase
    end
  end

  amdc_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .in_stall  (in_stall),
    .enable    (enable),
    .mix_valid (mix_valid),
    .mix_beat  (mix_beat),
    .mix_take  (mix_take)
  );

  amdc_lowpass u_lowpass (
    .clk         (clk),
    .rst         (rst),
    .mix_valid   (mix_valid),
    .mix_beat    (mix_beat),
    .mix_take    (mix_take),
    .filter_mode (filter_mode),
    .lp_valid    (lp_valid),
    .lp_beat     (lp_beat),
    .lp_take     (lp_take)
  );

  amdc_dc_cut #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dc_cut (
    .clk       (clk),
    .rst       (rst),
    .lp_valid  (lp_valid),
    .lp_beat   (lp_beat),
    .lp_take   (lp_take),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .out_stall (out_stall)
  );

endmodule

// ===== hw/rtl/amdc_mix.sv =====
// Input register and multiply-accumulate over the channel beats of one period.
// Depends on amdc_pkg.
module amdc_mix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  amdc_pkg::in_beat_t  in_beat,
  output logic                in_stall,
  input  logic                enable,
  output logic                mix_valid,
  output amdc_pkg::mix_beat_t mix_beat,
  input  logic                mix_take
);

  logic                 hold_valid;
  amdc_pkg::in_beat_t   hold;
  logic signed [31:0]   acc;
  logic signed [25:0]   prod;
  logic signed [31:0]   sum;
  logic                 advance;
  logic                 accept;

  assign prod    = $signed(hold.channel_sample) * $signed({1'b0, hold.channel_gain});
  assign sum     = acc + 32'(prod);
  assign advance = hold_valid && (!hold.last_channel || !mix_valid || mix_take);
  assign in_stall = hold_valid && !advance;
  assign accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      acc <= hold.last_channel ? 32'sd0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (advance && hold.last_channel) begin
      mix_valid <= 1'b1;
    end else if (mix_take) begin
      mix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold.last_channel) begin
      mix_beat.sum  <= sum;
      mix_beat.mute <= !enable;
    end
  end

endmodule

// ===== hw/rtl/amdc_lowpass.sv =====
// Scale-down by 256 and optional two- or three-tap low-pass with its history.
// Depends on amdc_pkg.
module amdc_lowpass (
  input  logic                clk,
  input  logic                rst,
  input  logic                mix_valid,
  input  amdc_pkg::mix_beat_t mix_beat,
  output logic                mix_take,
  input  logic [1:0]          filter_mode,
  output logic                lp_valid,
  output amdc_pkg::lp_beat_t  lp_beat,
  input  logic                lp_take
);

  logic signed [23:0] prev;
  logic signed [23:0] prev2;
  logic signed [23:0] x;
  logic signed [24:0] sum2;
  logic signed [26:0] sum3;
  logic signed [24:0] avg2;
  logic signed [26:0] avg3;
  logic signed [23:0] y;
  logic               upd;

  assign x    = mix_beat.sum[31:amdc_pkg::MIX_SHIFT];
  assign sum2 = 25'(prev) + 25'(x);
  assign sum3 = 27'(prev2) + (27'(prev) <<< 1) + 27'(x);
  assign avg2 = (sum2 + 25'(sum2[24])) >>> 1;
  assign avg3 = (sum3 + (sum3[26] ? 27'sd3 : 27'sd0)) >>> 2;

  always_comb begin
    case (filter_mode)
      amdc_pkg::FILT_TWO_TAP:   y = avg2[23:0];
      amdc_pkg::FILT_THREE_TAP: y = avg3[23:0];
      default:                  y = x;
    endcase
  end

  assign mix_take = mix_valid && (!lp_valid || lp_take);
  assign upd      = mix_take && !mix_beat.mute;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      prev2 <= '0;
    end else if (upd) begin
      if (filter_mode == amdc_pkg::FILT_TWO_TAP) begin
        prev <= y;
      end else if (filter_mode == amdc_pkg::FILT_THREE_TAP) begin
        prev  <= y;
        prev2 <= prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp_valid <= 1'b0;
    end else if (mix_take) begin
      lp_valid <= 1'b1;
    end else if (lp_take) begin
      lp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_take) begin
      lp_beat.x    <= y;
      lp_beat.mute <= mix_beat.mute;
    end
  end

endmodule

// ===== hw/rtl/amdc_dc_cut.sv =====
// Peak-tracking DC remover, 16-bit saturation and the result register.
// Depends on amdc_pkg.
module amdc_dc_cut #(
  parameter int FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                lp_valid,
  input  amdc_pkg::lp_beat_t  lp_beat,
  output logic                lp_take,
  output logic                out_valid,
  output amdc_pkg::out_beat_t out_beat,
  input  logic                out_stall
);

  localparam int W  = FRAC_BITS + 26;
  localparam int IW = W - FRAC_BITS;

  logic signed [W-1:0]  peak_high;
  logic signed [W-1:0]  peak_low;
  logic signed [W-1:0]  dc_average;
  logic signed [W-1:0]  xq;
  logic signed [W-1:0]  decay;
  logic signed [W-1:0]  high_dec;
  logic signed [W-1:0]  low_dec;
  logic signed [W-1:0]  high_next;
  logic signed [W-1:0]  low_next;
  logic signed [W-1:0]  dc_next;
  logic                 round_up;
  logic signed [IW-1:0] dc_int;
  logic signed [IW:0]   y;
  logic signed [15:0]   word;
  logic                 upd;

  assign xq        = W'(lp_beat.x) <<< FRAC_BITS;
  assign decay     = (peak_high - peak_low) >>> amdc_pkg::PEAK_DECAY_SHIFT;
  assign high_dec  = peak_high - decay;
  assign low_dec   = peak_low + decay;
  assign high_next = (xq > high_dec) ? xq : high_dec;
  assign low_next  = (xq < low_dec) ? xq : low_dec;
  assign dc_next   = dc_average - (dc_average >>> amdc_pkg::DC_LEAK_SHIFT)
                   + ((high_next + low_next) >>> amdc_pkg::DC_SUM_SHIFT);
  assign round_up  = dc_next[W-1] && (|dc_next[FRAC_BITS-1:0]);
  assign dc_int    = $signed(dc_next[W-1:FRAC_BITS]) + $signed(IW'({1'b0, round_up}));
  assign y         = (IW+1)'(lp_beat.x) - (IW+1)'(dc_int);

  always_comb begin
    if (lp_beat.mute) begin
      word = '0;
    end else if (y > amdc_pkg::WORD_MAX) begin
      word = 16'(amdc_pkg::WORD_MAX);
    end else if (y < amdc_pkg::WORD_MIN) begin
      word = 16'(amdc_pkg::WORD_MIN);
    end else begin
      word = y[15:0];
    end
  end

  assign lp_take = lp_valid && (!out_valid || !out_stall);
  assign upd     = lp_take && !lp_beat.mute;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_high  <= '0;
      peak_low   <= '0;
      dc_average <= '0;
    end else if (upd) begin
      peak_high  <= high_next;
      peak_low   <= low_next;
      dc_average <= dc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lp_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lp_take) begin
      out_beat.sample_word <= word;
      out_beat.sample_byte <= word[15:8] ^ amdc_pkg::BYTE_FLIP;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for audio_mix_filter_dc_cut: a directed script followed by
// random sample periods, each checked against a mixer model or a scripted result.
// Depends on amdc_pkg and the RTL under hw/rtl only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 24;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
  localparam int ITEMS = 1900;
  localparam int SETTLE = 12;
  localparam int LIMIT = 400000;
  localparam int SHOW_MAX = 10;

  localparam logic [0:0] REG_ENABLE = amdc_pkg::CFG_ENABLE;
  localparam logic [0:0] REG_FILTER = amdc_pkg::CFG_FILTER_MODE;
  localparam logic [7:0] FLIP = amdc_pkg::BYTE_FLIP;

  localparam logic [1:0] FILT_SPARE = 2'd3;
  localparam logic [1:0] EN_OFF_MASKED = 2'b10;
  localparam logic [1:0] EN_ON_MASKED = 2'b11;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    amdc_pkg::in_beat_t  beat;
    logic [0:0]          idx;
    logic [1:0]          data;
    logic                typed;
    amdc_pkg::out_beat_t res;
  } row_t;

  localparam row_t SCRIPT [0:24] = '{
    '{ROW_BEAT, '{16'h0000, 9'd0, 1'b1}, REG_ENABLE, 2'd0, 1'b1, '{16'h0000, FLIP}},
    '{ROW_BEAT, '{16'h7FFF, 9'd304, 1'b0}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h7FFF, 9'd304, 1'b0}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h8000, 9'd304, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h8000, 9'd511, 1'b0}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h7FFF, 9'd511, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h8000, 9'd511, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_REG, '0, REG_FILTER, amdc_pkg::FILT_TWO_TAP, 1'b0, '0},
    '{ROW_BEAT, '{16'h7FFF, 9'd256, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'hFFFF, 9'd1, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h7FFF, 9'd304, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_REG, '0, REG_FILTER, amdc_pkg::FILT_THREE_TAP, 1'b0, '0},
    '{ROW_BEAT, '{16'h3039, 9'd200, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h8000, 9'd304, 1'b0}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h8000, 9'd304, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h7FFF, 9'd304, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_REG, '0, REG_FILTER, FILT_SPARE, 1'b0, '0},
    '{ROW_BEAT, '{16'h03E8, 9'd100, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_REG, '0, REG_ENABLE, EN_OFF_MASKED, 1'b0, '0},
    '{ROW_BEAT, '{16'h7FFF, 9'd304, 1'b0}, REG_ENABLE, 2'd0, 1'b0, '0},
    '{ROW_BEAT, '{16'h0005, 9'd5, 1'b1}, REG_ENABLE, 2'd0, 1'b1, '{16'h0000, FLIP}},
    '{ROW_BEAT, '{16'h8000, 9'd511, 1'b1}, REG_ENABLE, 2'd0, 1'b1, '{16'h0000, FLIP}},
    '{ROW_REG, '0, REG_ENABLE, EN_ON_MASKED, 1'b0, '0},
    '{ROW_REG, '0, REG_FILTER, amdc_pkg::FILT_NONE, 1'b0, '0},
    '{ROW_BEAT, '{16'h0000, 9'd0, 1'b1}, REG_ENABLE, 2'd0, 1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  amdc_pkg::in_beat_t  in_beat;
  logic                in_stall;
  logic                out_valid;
  amdc_pkg::out_beat_t out_beat;
  logic                out_stall = 1'b0;
  logic                cfg_write;
  logic [0:0]          cfg_index;
  logic [1:0]          cfg_data;

  // mixer model state
  logic [31:0] mix_sum = '0;
  longint      lp_last = 0;
  longint      lp_older = 0;
  longint      peak_hi = 0;
  longint      peak_lo = 0;
  longint      dc_level = 0;
  logic        mix_on = 1'b1;
  logic [1:0]  lp_mode = amdc_pkg::FILT_NONE;

  amdc_pkg::out_beat_t pending [$];
  int        n_bad = 0;
  int        n_shown = 0;
  int        n_sent = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;

  audio_mix_filter_dc_cut #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_beat(in_beat),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_beat(out_beat),
    .out_stall(out_stall),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit mix_step(input amdc_pkg::in_beat_t b,
                                  output amdc_pkg::out_beat_t r);
    longint prod;
    longint x;
    longint d;
    logic [31:0] total;
    r = '0;
    prod = longint'($signed(b.channel_sample)) * longint'(b.channel_gain);
    mix_sum = mix_sum + prod[31:0];
    if (!b.last_channel) return 1'b0;
    total = mix_sum;
    mix_sum = '0;
    if (!mix_on) begin
      r.sample_byte = FLIP;
      return 1'b1;
    end
    x = longint'($signed(total)) >>> amdc_pkg::MIX_SHIFT;
    case (lp_mode)
      amdc_pkg::FILT_TWO_TAP: begin
        x = (lp_last + x) / 2;
        lp_last = x;
      end
      amdc_pkg::FILT_THREE_TAP: begin
        x = (lp_older + lp_last * 2 + x) / 4;
        lp_older = lp_last;
        lp_last = x;
      end
      default: ;
    endcase
    d = (peak_hi - peak_lo) >>> amdc_pkg::PEAK_DECAY_SHIFT;
    peak_hi = peak_hi - d;
    peak_lo = peak_lo + d;
    if (x * FRAC_ONE > peak_hi) peak_hi = x * FRAC_ONE;
    if (x * FRAC_ONE < peak_lo) peak_lo = x * FRAC_ONE;
    dc_level = dc_level - (dc_level >>> amdc_pkg::DC_LEAK_SHIFT);
    dc_level = dc_level + ((peak_hi + peak_lo) >>> amdc_pkg::DC_SUM_SHIFT);
    x = x - dc_level / FRAC_ONE;
    if (x > amdc_pkg::WORD_MAX) x = amdc_pkg::WORD_MAX;
    else if (x < amdc_pkg::WORD_MIN) x = amdc_pkg::WORD_MIN;
    r.sample_word = x[15:0];
    r.sample_byte = x[15:8] ^ FLIP;
    return 1'b1;
  endfunction

  task automatic send_beat(input amdc_pkg::in_beat_t b, input logic typed,
                           input amdc_pkg::out_beat_t res);
    amdc_pkg::out_beat_t got;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    if (mix_step(b, got)) pending.push_back(typed ? res : got);
    n_sent++;
    quiet = (n_sent >= 700 && n_sent < 1000);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_ENABLE) mix_on = data[0];
    else lp_mode = data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    amdc_pkg::out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        n_bad++;
        if (n_shown < SHOW_MAX) begin
          n_shown++;
          $display("unexpected beat at cycle %0d: word %0d byte %02h",
                   cycles, out_beat.sample_word, out_beat.sample_byte);
        end
      end else begin
        want = pending.pop_front();
        if (out_beat.sample_word !== want.sample_word ||
            out_beat.sample_byte !== want.sample_byte) begin
          n_bad++;
          if (n_shown < SHOW_MAX) begin
            n_shown++;
            $display("mismatch at cycle %0d: word exp %0d got %0d, byte exp %02h got %02h",
                     cycles, want.sample_word, out_beat.sample_word,
                     want.sample_byte, out_beat.sample_byte);
          end
        end
      end
    end
  end

  initial begin
    amdc_pkg::in_beat_t b;
    int         len;
    int         phase_end;
    bit         wrap;
    logic [15:0] big;
    rst = 1'b1;
    in_valid = 1'b0;
    in_beat = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_REG) begin
        drain();
        write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      end else begin
        send_beat(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].res);
      end
    end

    while (n_sent < ITEMS) begin
      drain();
      write_reg(REG_ENABLE, ($urandom_range(9) == 0) ? 2'($urandom_range(1) * 2)
                                                     : 2'($urandom_range(1) * 2 + 1));
      write_reg(REG_FILTER, 2'($urandom_range(3)));
      phase_end = n_sent + $urandom_range(80, 220);
      while (n_sent < phase_end) begin
        // a rare long period of full-scale beats wraps the accumulator
        wrap = ($urandom_range(39) == 0);
        len = wrap ? 140 : $urandom_range(1, 24);
        big = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        for (int k = 0; k < len; k++) begin
          if (wrap) begin
            b.channel_sample = big;
            b.channel_gain = 9'h1FF;
          end else begin
            case ($urandom_range(7))
              0: b.channel_sample = 16'h7FFF;
              1: b.channel_sample = 16'h8000;
              default: b.channel_sample = 16'($urandom);
            endcase
            case ($urandom_range(15))
              0, 1: b.channel_gain = 9'd0;
              2: b.channel_gain = 9'd304;
              3: b.channel_gain = 9'($urandom);
              default: b.channel_gain = 9'($urandom_range(304));
            endcase
          end
          b.last_channel = (k == len - 1);
          send_beat(b, 1'b0, '0);
        end
      end
    end
    drain();

    n_bad += pending.size();
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
